### rtl/sfm_pkg.sv
// shared types, constants and codes of the surface feature marker
// no dependencies; imported by the interfaces and every module of the block
package sfm_pkg;

	localparam int MAX_FEATURES_DEF = 4096;
	localparam int MAX_AXIS_DEF     = 256;
	localparam int ID_W             = 12;
	localparam int CFG_W            = 9;
	localparam int CFG_IDX_W        = 2;

	// word kinds
	localparam logic OP_VOXEL = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} cfg_reg_t;

	// flag store sequencing
	typedef enum logic {
		FLG_CLEAR,
		FLG_RUN
	} flag_state_t;

	// mark slots of one voxel
	localparam int N_SLOTS   = 4;
	localparam int SLOT_SELF = 0;
	localparam int SLOT_X    = 1;
	localparam int SLOT_Y    = 2;
	localparam int SLOT_Z    = 3;

	typedef struct packed {
		logic has_x;
		logic has_y;
		logic has_z;
		logic on_edge;
	} nbr_info_t;

	typedef struct packed {
		logic mark;
		logic query;
	} flag_cmd_t;

endpackage

### rtl/sfm_if.sv
// valid/ready channel interfaces for input words and result words
// depends on sfm_pkg for the id width
interface sfm_in_if import sfm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            op;
	logic [ID_W-1:0] voxel_feature;
	logic [ID_W-1:0] query_feature;

	modport source (output valid, output op, output voxel_feature, output query_feature,
		input ready);
	modport sink (input valid, input op, input voxel_feature, input query_feature,
		output ready);
endinterface

interface sfm_out_if import sfm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            surface_flag;
	logic [ID_W-1:0] flag_feature;

	modport source (output valid, output surface_flag, output flag_feature, input ready);
	modport sink (input valid, input surface_flag, input flag_feature, output ready);
endinterface

### rtl/sfm_raster.sv
// raster position counters, plane buffer pointer and size registers
// depends on sfm_pkg
module sfm_raster import sfm_pkg::*; #(
	parameter int MAX_AXIS = MAX_AXIS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic                           step,
	output logic [2*$clog2(MAX_AXIS)-1:0]  ptr,
	output logic [2*$clog2(MAX_AXIS)-1:0]  up_ptr,
	output nbr_info_t                      info
);

	localparam int AW = $clog2(MAX_AXIS);
	localparam int SW = $clog2(MAX_AXIS + 1);
	localparam int PW = 2 * AW;

	logic [SW-1:0] size_x_q, size_y_q, size_z_q;
	logic [AW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [PW-1:0] ptr_q;
	logic          cfg_hit;
	logic          x_last, y_last, z_last;

	function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		if (w == 32'd0) begin
			w = 32'd1;
		end else if (w > 32'(MAX_AXIS)) begin
			w = 32'(MAX_AXIS);
		end
		return SW'(w);
	endfunction

	function automatic logic at_edge(input logic [AW-1:0] c, input logic [SW-1:0] n);
		return (n > SW'(1)) && ((c == '0) || (SW'(c) == n - SW'(1)));
	endfunction

	always_comb begin
		cfg_hit = 1'b0;
		case (cfg_reg_t'(cfg_index))
			REG_SIZE_X: cfg_hit = cfg_wr_en;
			REG_SIZE_Y: cfg_hit = cfg_wr_en;
			REG_SIZE_Z: cfg_hit = cfg_wr_en;
			default:    cfg_hit = 1'b0;
		endcase
	end

	assign x_last = (SW'(pos_x_q) + SW'(1)) >= size_x_q;
	assign y_last = (SW'(pos_y_q) + SW'(1)) >= size_y_q;
	assign z_last = (SW'(pos_z_q) + SW'(1)) >= size_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SW'(1);
			size_y_q <= SW'(1);
			size_z_q <= SW'(1);
		end else if (cfg_hit) begin
			case (cfg_reg_t'(cfg_index))
				REG_SIZE_X: size_x_q <= clamp_size(cfg_data);
				REG_SIZE_Y: size_y_q <= clamp_size(cfg_data);
				REG_SIZE_Z: size_z_q <= clamp_size(cfg_data);
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			ptr_q   <= '0;
		end else if (cfg_hit) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			ptr_q   <= '0;
		end else if (step) begin
			if (!x_last) begin
				pos_x_q <= pos_x_q + AW'(1);
				ptr_q   <= ptr_q + PW'(1);
			end else begin
				pos_x_q <= '0;
				if (!y_last) begin
					pos_y_q <= pos_y_q + AW'(1);
					ptr_q   <= ptr_q + PW'(1);
				end else begin
					pos_y_q <= '0;
					ptr_q   <= '0;
					pos_z_q <= z_last ? '0 : pos_z_q + AW'(1);
				end
			end
		end
	end

	assign ptr          = ptr_q;
	assign up_ptr       = ptr_q - PW'(size_x_q);
	assign info.has_x   = pos_x_q != '0;
	assign info.has_y   = pos_y_q != '0;
	assign info.has_z   = pos_z_q != '0;
	assign info.on_edge = at_edge(pos_x_q, size_x_q) || at_edge(pos_y_q, size_y_q) ||
		at_edge(pos_z_q, size_z_q);

endmodule

### rtl/sfm_plane_mem.sv
// one-plane circular buffer of feature ids, one write and two registered reads
// depends on sfm_pkg for the id width
module sfm_plane_mem import sfm_pkg::*; #(
	parameter int PW = 16
) (
	input  logic            clk,
	input  logic            we,
	input  logic [PW-1:0]   waddr,
	input  logic [ID_W-1:0] wdata,
	input  logic            re,
	input  logic [PW-1:0]   raddr_a,
	input  logic [PW-1:0]   raddr_b,
	output logic [ID_W-1:0] rdata_a,
	output logic [ID_W-1:0] rdata_b
);

	logic [ID_W-1:0] mem [2**PW];
	logic [ID_W-1:0] rdata_a_q, rdata_b_q;

	// read returns the old word when the write hits the same entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

### rtl/sfm_flag_mem.sv
// surface flag store with clearing pass after reset and read-and-clear access
// depends on sfm_pkg
module sfm_flag_mem import sfm_pkg::*; #(
	parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  flag_cmd_t                       cmd,
	input  logic [$clog2(MAX_FEATURES)-1:0] addr,
	output logic                            rd_flag,
	output logic                            busy
);

	localparam int FW = $clog2(MAX_FEATURES);

	flag_state_t state_q, state_d;
	logic [FW-1:0] clr_q;
	logic          mem [MAX_FEATURES];
	logic          rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FLG_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		case (state_q)
			FLG_CLEAR: begin
				busy = 1'b1;
				if (clr_q == FW'(MAX_FEATURES - 1)) begin
					state_d = FLG_RUN;
				end
			end
			FLG_RUN: state_d = FLG_RUN;
			default: state_d = FLG_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + FW'(1);
		end
	end

	// query reads the old flag and clears it in the same cycle
	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q] <= 1'b0;
		end else if (cmd.mark) begin
			mem[addr] <= 1'b1;
		end else if (cmd.query) begin
			mem[addr] <= 1'b0;
		end
		if (cmd.query) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_flag = rd_q;

endmodule

### rtl/surface_feature_marker_top.sv
// surface feature marker: raster walk, plane buffer and flag store
// a query word waits in stage 1 until the result register is free, then its result word is registered there
// one word per cycle while stage 1 drains; a voxel that sets more than one flag holds the flag port, one mark per flag
// the single-port flag store (one mark or query a cycle) sets that limit
// reset: a clearing pass over all MAX_FEATURES entries zeroes the flags, no word is accepted meanwhile
// depends on sfm_pkg, sfm_if, sfm_raster, sfm_plane_mem, sfm_flag_mem
module surface_feature_marker_top import sfm_pkg::*; #(
	parameter int MAX_FEATURES = MAX_FEATURES_DEF,
	parameter int MAX_AXIS     = MAX_AXIS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sfm_in_if.sink               items,
	sfm_out_if.source            results
);

	localparam int AW = $clog2(MAX_AXIS);
	localparam int PW = 2 * AW;
	localparam int FW = $clog2(MAX_FEATURES);

	// raster side
	logic [PW-1:0]   ptr, up_ptr;
	nbr_info_t       info;
	logic            in_acc, voxel_acc;
	logic [ID_W-1:0] prev_q;
	logic [ID_W-1:0] nb_z, nb_y;

	// stage 1: word waiting on the flag port
	logic            valid_s1;
	logic            op_s1;
	logic [ID_W-1:0] feat_s1;
	logic [ID_W-1:0] nb_x_s1;
	nbr_info_t       info_s1;
	logic [N_SLOTS-1:0] done_q;

	logic [N_SLOTS-1:0] mask, pending, sel;
	logic [ID_W-1:0]    mark_id;
	logic               is_voxel, is_query, last_mark, out_free, s1_done, s1_free;

	// flag store and result register
	flag_cmd_t       flag_cmd;
	logic [FW-1:0]   flag_addr;
	logic            rd_flag, flag_busy;
	logic            out_valid_q, out_ok_q;
	logic [ID_W-1:0] out_feat_q;

	// ids at or beyond the table size are never marked
	function automatic logic feat_ok(input logic [ID_W-1:0] f);
		return 32'(f) < 32'(MAX_FEATURES);
	endfunction

	assign in_acc    = items.valid && items.ready;
	assign voxel_acc = in_acc && (items.op == OP_VOXEL);

	sfm_raster #(.MAX_AXIS(MAX_AXIS)) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (voxel_acc),
		.ptr       (ptr),
		.up_ptr    (up_ptr),
		.info      (info)
	);

	// port a reads the voxel one plane back, port b the one a row back;
	// the write of the current voxel lands on port a's entry after its read
	sfm_plane_mem #(.PW(PW)) u_plane (
		.clk     (clk),
		.we      (voxel_acc),
		.waddr   (ptr),
		.wdata   (items.voxel_feature),
		.re      (voxel_acc),
		.raddr_a (ptr),
		.raddr_b (up_ptr),
		.rdata_a (nb_z),
		.rdata_b (nb_y)
	);

	// stage 1 load; the x neighbour is simply the previous voxel word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= items.op;
			feat_s1 <= (items.op == OP_VOXEL) ? items.voxel_feature : items.query_feature;
			nb_x_s1 <= prev_q;
			info_s1 <= info;
		end
		if (voxel_acc) begin
			prev_q <= items.voxel_feature;
		end
	end

	// marks a voxel asks for: itself, and each earlier neighbour when it is background
	always_comb begin
		mask = '0;
		mask[SLOT_SELF] = feat_ok(feat_s1) && (info_s1.on_edge ||
			(info_s1.has_x && nb_x_s1 == '0) ||
			(info_s1.has_y && nb_y == '0) ||
			(info_s1.has_z && nb_z == '0));
		mask[SLOT_X] = (feat_s1 == '0) && info_s1.has_x && feat_ok(nb_x_s1);
		mask[SLOT_Y] = (feat_s1 == '0) && info_s1.has_y && feat_ok(nb_y);
		mask[SLOT_Z] = (feat_s1 == '0) && info_s1.has_z && feat_ok(nb_z);
	end

	assign pending   = mask & ~done_q;
	assign sel       = pending & (~pending + N_SLOTS'(1));
	assign last_mark = (pending & ~sel) == '0;

	always_comb begin
		if (sel[SLOT_SELF]) begin
			mark_id = feat_s1;
		end else if (sel[SLOT_X]) begin
			mark_id = nb_x_s1;
		end else if (sel[SLOT_Y]) begin
			mark_id = nb_y;
		end else begin
			mark_id = nb_z;
		end
	end

	assign is_voxel = valid_s1 && (op_s1 == OP_VOXEL);
	assign is_query = valid_s1 && (op_s1 == OP_QUERY);
	assign out_free = !out_valid_q || results.ready;
	assign s1_done  = is_voxel ? last_mark : out_free;
	assign s1_free  = !valid_s1 || s1_done;

	// next word enters as soon as stage 1 drains, even while a result word waits
	assign items.ready = !flag_busy && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= '0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && s1_done) begin
				done_q <= '0;
			end else if (flag_cmd.mark) begin
				done_q <= done_q | sel;
			end
		end
	end

	assign flag_cmd.mark  = is_voxel && (pending != '0);
	assign flag_cmd.query = is_query && out_free && feat_ok(feat_s1);
	assign flag_addr      = flag_cmd.mark ? FW'(mark_id) : FW'(feat_s1);

	sfm_flag_mem #(.MAX_FEATURES(MAX_FEATURES)) u_flags (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (flag_cmd),
		.addr    (flag_addr),
		.rd_flag (rd_flag),
		.busy    (flag_busy)
	);

	// result register; the flag itself comes from the store's read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_query && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_query && out_free) begin
			out_feat_q <= feat_s1;
			out_ok_q   <= feat_ok(feat_s1);
		end
	end

	assign results.valid        = out_valid_q;
	assign results.surface_flag = out_ok_q & rd_flag;
	assign results.flag_feature = out_feat_q;

	// no word is taken during the clearing pass
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		flag_busy |-> !items.ready)
		else $error("word accepted during flag clearing pass");

	// the flag port carries one access a cycle
	a_one_flag_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(flag_cmd.mark && flag_cmd.query))
		else $error("mark and query on the flag port together");

	// marks already written belong to the current voxel's request set
	a_done_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q & ~mask) == '0)
		else $error("mark sequencer out of step with stage 1");

	// a query blocked by a full result register stays put
	a_query_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(is_query && !out_free) |=> (valid_s1 && $stable(feat_s1)))
		else $error("blocked query lost from stage 1");

endmodule

### tb/surface_feature_marker_top_tb.sv
// self-checking testbench for surface_feature_marker_top: raster voxel words and flag queries
// depends on sfm_pkg, sfm_in_if / sfm_out_if and the block itself; keeps its own flag predictor
module surface_feature_marker_top_tb import sfm_pkg::*; ();

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned POOL_N        = 6;

	typedef struct {
		logic            flag;
		logic [ID_W-1:0] feature;
	} flag_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	sfm_in_if  items_if ();
	sfm_out_if results_if ();

	surface_feature_marker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items_if),
		.results   (results_if)
	);

	// predictor state: flag table, one plane of ids and the raster position
	logic            flag_table [MAX_FEATURES_DEF];
	logic [ID_W-1:0] plane_ids [MAX_AXIS_DEF*MAX_AXIS_DEF];
	int unsigned     dim_x, dim_y, dim_z;
	int unsigned     px, py, pz, plane_ptr;

	// query results still owed by the block, oldest first
	flag_result_t flag_results_due [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned words_sent;
	int unsigned mismatches;
	int unsigned cycle_count;
	bit          hold_req;
	bit          holding;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic bit at_boundary(int unsigned c, int unsigned n);
		return n > 1 && (c == 0 || c == n - 1);
	endfunction

	// background on either side of a face marks the other side
	function automatic void pair_marks(logic [ID_W-1:0] cur, logic [ID_W-1:0] nb);
		if (cur == '0) begin
			flag_table[nb] = 1'b1;
		end
		if (nb == '0) begin
			flag_table[cur] = 1'b1;
		end
	endfunction

	function automatic void trace_voxel(logic [ID_W-1:0] v);
		if (at_boundary(px, dim_x) || at_boundary(py, dim_y) || at_boundary(pz, dim_z)) begin
			flag_table[v] = 1'b1;
		end
		// earlier x and y neighbours sit behind the write pointer in the plane, the z neighbour at it
		if (px > 0) begin
			pair_marks(v, plane_ids[plane_ptr - 1]);
		end
		if (py > 0) begin
			pair_marks(v, plane_ids[plane_ptr - dim_x]);
		end
		if (pz > 0) begin
			pair_marks(v, plane_ids[plane_ptr]);
		end
		plane_ids[plane_ptr] = v;
		px++;
		if (px >= dim_x) begin
			px = 0;
			py++;
			if (py >= dim_y) begin
				py = 0;
				pz++;
				if (pz >= dim_z) begin
					pz = 0;
				end
			end
		end
		plane_ptr = py * dim_x + px;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what);
		mismatches++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// every result word is matched against the oldest query still owed
	always @(posedge clk) begin : check_results
		flag_result_t due;
		if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			if (flag_results_due.size() == 0) begin
				report_mismatch($sformatf("result word for feature %0d with no query pending",
					results_if.flag_feature));
			end else begin
				due = flag_results_due.pop_front();
				if (results_if.flag_feature !== due.feature) begin
					report_mismatch($sformatf("flag_feature %0d, wanted %0d",
						results_if.flag_feature, due.feature));
				end
				if (results_if.surface_flag !== due.flag) begin
					report_mismatch($sformatf("surface_flag %b for feature %0d, wanted %b",
						results_if.surface_flag, due.feature, due.flag));
				end
			end
		end
	end

	// cycle counter doubles as the watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- result side

	// receiver ready, random stalls plus the long hold-off window
	always @(negedge clk) begin
		results_if.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
	end

	// long hold-off, counted here so the sender keeps offering words meanwhile
	initial begin
		holding = 1'b0;
		wait (hold_req);
		@(posedge clk);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding = 1'b0;
	end

	// ---------------------------------------------------------------- word and register drivers

	// one word, random idle cycles ahead of it; predicted at acceptance
	task automatic send_word(logic op, logic [ID_W-1:0] vf, logic [ID_W-1:0] qf);
		flag_result_t due;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid         <= 1'b1;
		items_if.op            <= op;
		items_if.voxel_feature <= vf;
		items_if.query_feature <= qf;
		do @(posedge clk); while (items_if.ready !== 1'b1);
		words_sent++;
		if (op == OP_QUERY) begin
			// read and clear; the voxel field plays no part
			due.flag    = flag_table[qf];
			due.feature = qf;
			flag_results_due = {flag_results_due, due};
			flag_table[qf] = 1'b0;
		end else begin
			trace_voxel(vf);
		end
	endtask

	// stop offering, wait for owed results, then let trailing voxel marks finish
	task automatic drain_block();
		@(negedge clk);
		items_if.valid <= 1'b0;
		while (flag_results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// any register write restarts the raster; flags survive
	task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] raw);
		int unsigned eff;
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= raw;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		// zero acts as one, anything past the axis limit as the limit
		eff = (raw == '0) ? 1 : ((raw > MAX_AXIS_DEF) ? MAX_AXIS_DEF : 32'(raw));
		case (idx)
			REG_SIZE_X: dim_x = eff;
			REG_SIZE_Y: dim_y = eff;
			default:    dim_z = eff;
		endcase
		px        = 0;
		py        = 0;
		pz        = 0;
		plane_ptr = 0;
	endtask

	task automatic set_volume(logic [CFG_W-1:0] rx, logic [CFG_W-1:0] ry, logic [CFG_W-1:0] rz);
		cfg_write(REG_SIZE_X, rx);
		cfg_write(REG_SIZE_Y, ry);
		cfg_write(REG_SIZE_Z, rz);
	endtask

	// voxel words drawn from a small id pool with runs and background,
	// stray queries in between, then every pool id is read back
	task automatic send_volume(int unsigned count, int unsigned query_pct);
		logic [ID_W-1:0] pool [POOL_N];
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] prev;
		int unsigned     r;
		for (int j = 0; j < POOL_N; j++) begin
			case ($urandom_range(9))
				0:       pool[j] = 12'd1;
				1:       pool[j] = '1;
				default: pool[j] = ID_W'($urandom_range(1, 4095));
			endcase
		end
		prev = pool[0];
		for (int unsigned n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 22) begin
				id = '0;
			end else if (r < 55) begin
				id = prev;
			end else if (r < 95) begin
				id = pool[$urandom_range(POOL_N - 1)];
			end else begin
				id = ID_W'($urandom_range(4095));
			end
			prev = id;
			send_word(OP_VOXEL, id, ID_W'($urandom_range(4095)));
			if ($urandom_range(99) < query_pct) begin
				send_word(OP_QUERY, ID_W'($urandom_range(4095)),
					pool[$urandom_range(POOL_N - 1)]);
			end
		end
		for (int j = 0; j < POOL_N; j++) begin
			send_word(OP_QUERY, ID_W'($urandom_range(4095)), pool[j]);
		end
		send_word(OP_QUERY, ID_W'($urandom_range(4095)), ID_W'($urandom_range(4095)));
	endtask

	// ---------------------------------------------------------------- tests

	// reset sizes are all one: a lone voxel never marks anything
	task automatic test_reset_state();
		send_word(OP_VOXEL, 12'd5, '1);
		send_word(OP_VOXEL, 12'd0, '1);
		send_word(OP_QUERY, '1, 12'd5);
		send_word(OP_QUERY, '1, 12'd0);
	endtask

	// one row: background marks its earlier neighbour and the one after it
	task automatic test_row_background();
		drain_block();
		set_volume(9'd5, 9'd1, 9'd1);
		send_word(OP_VOXEL, 12'd1, '0);
		send_word(OP_VOXEL, 12'd2, '1);
		send_word(OP_VOXEL, 12'd0, '1);
		send_word(OP_VOXEL, 12'd3, '1);
		send_word(OP_VOXEL, 12'd4, '0);
		send_word(OP_QUERY, '1, 12'd2);
		send_word(OP_QUERY, '0, 12'd3);
	endtask

	// zero size acts as one, oversize acts as the axis limit; partial volume
	task automatic test_size_clamping();
		drain_block();
		set_volume(9'd0, 9'd511, 9'd1);
		send_word(OP_VOXEL, 12'hFFF, '1);
		send_word(OP_VOXEL, 12'd0, '1);
		send_word(OP_VOXEL, 12'd2048, '1);
		send_word(OP_VOXEL, 12'd1, '1);
		send_word(OP_QUERY, '1, 12'd1);
		send_word(OP_QUERY, '1, 12'd2048);
		send_word(OP_QUERY, '1, 12'hFFF);
	endtask

	// 2d plane: an interior feature with no background beside it stays unmarked
	task automatic test_interior_voxel();
		drain_block();
		set_volume(9'd3, 9'd3, 9'd1);
		for (int n = 0; n < 9; n++) begin
			send_word(OP_VOXEL, (n == 4) ? 12'd7 : 12'd9, ID_W'($urandom_range(4095)));
		end
		send_word(OP_QUERY, '0, 12'd7);
		send_word(OP_QUERY, '0, 12'd9);
		send_word(OP_QUERY, '1, 12'd9);
	endtask

	// full-length rows and a full-height column at the axis limit
	task automatic test_largest_sizes();
		drain_block();
		set_volume(9'd256, 9'd2, 9'd1);
		send_volume(512, 2);
		drain_block();
		set_volume(9'd1, 9'd1, 9'd300);
		send_volume(256, 2);
	endtask

	// result side held off while queries keep coming, so the input must stall
	task automatic test_result_backlog();
		drain_block();
		set_volume(9'd4, 9'd4, 9'd2);
		hold_req = 1'b1;
		send_volume(32, 100);
	endtask

	// mostly well-formed volumes of random shape and content,
	// some cut short by a register write, some with degenerate or clamped axes
	task automatic test_random_volumes(int unsigned target);
		int unsigned      start;
		int unsigned      sel;
		int unsigned      vol;
		int unsigned      count;
		int unsigned      first;
		logic [CFG_W-1:0] raw [3];
		start = words_sent;
		while (words_sent - start < target) begin
			drain_block();
			sel = $urandom_range(9);
			if (sel == 0) begin
				// each axis of size one or two, zero acting as one
				for (int k = 0; k < 3; k++) begin
					raw[k] = CFG_W'($urandom_range(0, 2));
				end
			end else begin
				raw[0] = CFG_W'($urandom_range(1, 6));
				raw[1] = CFG_W'($urandom_range(1, 6));
				raw[2] = CFG_W'(($urandom_range(3) == 0) ? 1 : $urandom_range(1, 5));
				if (sel == 1) begin
					raw[$urandom_range(2)] = $urandom_range(1) ? 9'd0 :
						CFG_W'($urandom_range(257, 511));
				end
			end
			first = $urandom_range(2);
			for (int j = 0; j < 3; j++) begin
				cfg_write(cfg_reg_t'((first + j) % 3), raw[(first + j) % 3]);
			end
			vol = dim_x * dim_y * dim_z;
			if (sel == 1) begin
				count = $urandom_range(1, 16);
			end else begin
				case ($urandom_range(7))
					0:       count = $urandom_range(1, vol);
					1:       count = 2 * vol;
					default: count = vol;
				endcase
			end
			send_volume(count, 8);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		items_if.valid         = 1'b0;
		items_if.op            = OP_VOXEL;
		items_if.voxel_feature = '0;
		items_if.query_feature = '0;
		results_if.ready       = 1'b0;
		cfg_wr_en              = 1'b0;
		cfg_index              = REG_SIZE_X;
		cfg_data               = '0;
		arst_n                 = 1'b0;
		hold_req               = 1'b0;
		words_sent             = 0;
		mismatches             = 0;
		cycle_count            = 0;
		for (int f = 0; f < MAX_FEATURES_DEF; f++) begin
			flag_table[f] = 1'b0;
		end
		dim_x     = 1;
		dim_y     = 1;
		dim_z     = 1;
		px        = 0;
		py        = 0;
		pz        = 0;
		plane_ptr = 0;

		// phase one: sender mostly busy, receiver stalls often
		send_idle_pct = 11;
		recv_idle_pct = 48;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_row_background();
		test_size_clamping();
		test_interior_voxel();
		test_random_volumes(200);

		// phase two: the other way round
		drain_block();
		send_idle_pct = 48;
		recv_idle_pct = 11;
		test_largest_sizes();
		test_random_volumes(200);

		// phase three: no idling anywhere
		drain_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_result_backlog();
		test_random_volumes(200);

		drain_block();
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
